@@ rtl/mbs_pkg.sv @@
package mbs_pkg;

  localparam int COORD_W = 32;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;

  // Three coordinates of one vertex, x at index 0.
  typedef logic [2:0][COORD_W-1:0] vec3_t;

  typedef struct packed {
    logic load;
    logic clear_pass;
    logic rd;
    logic sqrt_init;
    logic sqrt_step;
    logic emit_empty;
    logic emit_full;
  } mbs_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic last_addr;
    logic pipe_empty;
  } mbs_sts_t;

  function automatic logic [COORD_W-1:0] smin(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [COORD_W-1:0] smax(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

endpackage

@@ rtl/mbs_ram.sv @@
module mbs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mbs_dp.sv @@
module mbs_dp
  import mbs_pkg::*;
#(
  parameter int MAX_TRIANGLES = 1024,
  parameter int CNT_W         = 11,
  parameter int AW            = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mbs_cmd_t           cmd,
  output mbs_sts_t           sts,
  input  vec3_t              v0,
  input  vec3_t              v1,
  input  vec3_t              v2,
  output logic               out_valid,
  output vec3_t              out_center,
  output logic [ROOT_W-1:0]  out_radius,
  output logic               out_empty_res,
  output logic               out_overflowed
);

  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  vec3_t              low_r, high_r, center_r;
  logic [AW-1:0]      pidx_r;
  logic [4:0]         vld_r;
  vec3_t              rd0, rd1, rd2;
  logic [COORD_W-1:0] diff_r [3][3];
  logic [SQ_W-1:0]    prod_r [3][3];
  logic [SQ_W-1:0]    sum_r  [3];
  logic [SQ_W-1:0]    lmax_r, best_r;
  logic [SQ_W-1:0]    n_r;
  logic [ROOT_W+1:0]  rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic               out_valid_r, out_empty_r, out_ovf_r;
  vec3_t              out_center_r;
  logic [ROOT_W-1:0]  out_radius_r;

  logic               room;
  logic               we;
  vec3_t              rdv [3];
  logic [ROOT_W+3:0]  sq_shift, sq_trial;
  logic [SQ_W-1:0]    m01, m012;

  assign room = (cnt_r < CNT_W'(MAX_TRIANGLES));
  assign we   = cmd.load && room;

  mbs_ram #(.WIDTH(3*COORD_W), .DEPTH(MAX_TRIANGLES), .AW(AW)) u_ram0 (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(v0), .raddr(pidx_r), .rdata(rd0)
  );
  mbs_ram #(.WIDTH(3*COORD_W), .DEPTH(MAX_TRIANGLES), .AW(AW)) u_ram1 (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(v1), .raddr(pidx_r), .rdata(rd1)
  );
  mbs_ram #(.WIDTH(3*COORD_W), .DEPTH(MAX_TRIANGLES), .AW(AW)) u_ram2 (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(v2), .raddr(pidx_r), .rdata(rd2)
  );

  assign rdv[0] = rd0;
  assign rdv[1] = rd1;
  assign rdv[2] = rd2;

  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.last_addr  = (CNT_W'(pidx_r) == cnt_r - CNT_W'(1));
  assign sts.pipe_empty = ~|vld_r;

  // Load side: running box, seeded by the first triangle of the mesh.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      low_r  <= '0;
      high_r <= '0;
    end else if (cmd.emit_empty || cmd.emit_full) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      low_r  <= '0;
      high_r <= '0;
    end else if (cmd.load) begin
      if (room) begin
        cnt_r <= cnt_r + CNT_W'(1);
        for (int k = 0; k < 3; k++) begin
          if (cnt_r == '0) begin
            low_r[k]  <= smin(smin(v0[k], v1[k]), v2[k]);
            high_r[k] <= smax(smax(v0[k], v1[k]), v2[k]);
          end else begin
            low_r[k]  <= smin(smin(smin(low_r[k], v0[k]), v1[k]), v2[k]);
            high_r[k] <= smax(smax(smax(high_r[k], v0[k]), v1[k]), v2[k]);
          end
        end
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Pass control: read index and valid bits along the distance pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pidx_r <= '0;
      vld_r  <= '0;
    end else begin
      vld_r <= {vld_r[3:0], cmd.rd};
      if (cmd.clear_pass) begin
        pidx_r <= '0;
      end else if (cmd.rd) begin
        pidx_r <= pidx_r + AW'(1);
      end
    end
  end

  assign m01  = (sum_r[0] > sum_r[1]) ? sum_r[0] : sum_r[1];
  assign m012 = (m01 > sum_r[2]) ? m01 : sum_r[2];

  always_ff @(posedge clk) begin
    logic signed [COORD_W:0] d;
    logic [COORD_W+1:0]      s;
    logic [SQ_W+1:0]         sq_sum;
    if (cmd.clear_pass) begin
      for (int k = 0; k < 3; k++) begin
        s = {low_r[k][COORD_W-1], low_r[k]} + {high_r[k][COORD_W-1], high_r[k]};
        center_r[k] <= s[COORD_W:1];
      end
    end
    for (int l = 0; l < 3; l++) begin
      for (int k = 0; k < 3; k++) begin
        d = $signed({rdv[l][k][COORD_W-1], rdv[l][k]})
          - $signed({center_r[k][COORD_W-1], center_r[k]});
        diff_r[l][k] <= d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
        prod_r[l][k] <= SQ_W'(diff_r[l][k]) * SQ_W'(diff_r[l][k]);
      end
      sq_sum = 66'(prod_r[l][0]) + 66'(prod_r[l][1]) + 66'(prod_r[l][2]);
      sum_r[l] <= (|sq_sum[SQ_W+1:SQ_W]) ? '1 : sq_sum[SQ_W-1:0];
    end
    lmax_r <= m012;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (cmd.clear_pass) begin
      best_r <= '0;
    end else if (vld_r[4] && lmax_r > best_r) begin
      best_r <= lmax_r;
    end
  end

  // Restoring square root, one result bit per step.
  assign sq_shift = {rem_r, n_r[SQ_W-1:SQ_W-2]};
  assign sq_trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      n_r    <= best_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      n_r <= {n_r[SQ_W-3:0], 2'b00};
      if (sq_shift >= sq_trial) begin
        rem_r  <= (ROOT_W+2)'(sq_shift - sq_trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= sq_shift[ROOT_W+1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_empty || cmd.emit_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      out_center_r <= '0;
      out_radius_r <= '0;
      out_empty_r  <= 1'b1;
      out_ovf_r    <= 1'b0;
    end else if (cmd.emit_full) begin
      out_center_r <= center_r;
      out_radius_r <= root_r;
      out_empty_r  <= 1'b0;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_center     = out_center_r;
  assign out_radius     = out_radius_r;
  assign out_empty_res  = out_empty_r;
  assign out_overflowed = out_ovf_r;

endmodule

@@ rtl/mbs_ctrl.sv @@
module mbs_ctrl
  import mbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_has_triangle,
  input  logic     in_last,
  input  mbs_sts_t sts,
  output logic     busy,
  output mbs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PASS  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [4:0] LAST_STEP = 5'(ROOT_W - 1);

  logic [2:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = accept && in_has_triangle;
        if (accept && in_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.cnt_zero) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.clear_pass = 1'b1;
          state_nxt      = S_PASS;
        end
      end
      S_PASS: begin
        cmd.rd = 1'b1;
        if (sts.last_addr) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.sqrt_init = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 5'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit_full = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd, cmd.sqrt_step, cmd.emit_empty, cmd.emit_full}))
    else $error("more than one datapath action in a cycle");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy && start)
    else $error("triangle loaded outside an input transfer");

  a_root_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_init |-> sts.pipe_empty)
    else $error("square root started before the distance pass drained");

  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && step_r == LAST_STEP) |=> cmd.emit_full)
    else $error("result not emitted after the last root step");

endmodule

@@ rtl/mesh_bounding_sphere_top.sv @@
// Bounding sphere of a triangle mesh, signed Q16.16 coordinates.
// Input: one triangle per transfer, taken when start is high and busy is low.
// in_has_triangle marks a triangle, in_last ends the mesh. All three vertices of
// a triangle go into three vertex RAMs at once. After the last item the block
// is busy: a check state, then a distance pass reading one triangle per cycle,
// a drain of the distance pipeline that loads the root unit, a bit-serial
// square root and a state to post the result; an empty mesh is answered
// straight from the check state.
// The result shows on the out_ ports for exactly one cycle with out_valid;
// the receiver cannot stall it. An empty mesh gives out_empty_res with zeros.
// Triangles beyond MAX_TRIANGLES are dropped and reported by out_overflowed.
// Reset (rst_n, synchronous) clears the count, box and flags; the vertex RAMs
// need no clearing since a pass reads only entries of the current mesh.
module mesh_bounding_sphere_top
  import mbs_pkg::*;
#(
  parameter int MAX_TRIANGLES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_has_triangle,
  input  logic                      in_last,
  input  logic signed [COORD_W-1:0] in_v0_x,
  input  logic signed [COORD_W-1:0] in_v0_y,
  input  logic signed [COORD_W-1:0] in_v0_z,
  input  logic signed [COORD_W-1:0] in_v1_x,
  input  logic signed [COORD_W-1:0] in_v1_y,
  input  logic signed [COORD_W-1:0] in_v1_z,
  input  logic signed [COORD_W-1:0] in_v2_x,
  input  logic signed [COORD_W-1:0] in_v2_y,
  input  logic signed [COORD_W-1:0] in_v2_z,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_center_x,
  output logic signed [COORD_W-1:0] out_center_y,
  output logic signed [COORD_W-1:0] out_center_z,
  output logic        [ROOT_W-1:0]  out_radius,
  output logic                      out_empty_res,
  output logic                      out_overflowed
);

  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam int AW    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  mbs_cmd_t cmd;
  mbs_sts_t sts;
  vec3_t    v0, v1, v2, center;

  assign v0 = {in_v0_z, in_v0_y, in_v0_x};
  assign v1 = {in_v1_z, in_v1_y, in_v1_x};
  assign v2 = {in_v2_z, in_v2_y, in_v2_x};

  mbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_has_triangle(in_has_triangle),
    .in_last(in_last), .sts(sts), .busy(busy), .cmd(cmd)
  );

  mbs_dp #(.MAX_TRIANGLES(MAX_TRIANGLES), .CNT_W(CNT_W), .AW(AW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .v0(v0), .v1(v1), .v2(v2),
    .out_valid(out_valid), .out_center(center), .out_radius(out_radius),
    .out_empty_res(out_empty_res), .out_overflowed(out_overflowed)
  );

  assign out_center_x = center[0];
  assign out_center_y = center[1];
  assign out_center_z = center[2];

endmodule

@@ sim/mesh_bounding_sphere_top_tb.sv @@
`timescale 1ns / 1ps

module mesh_bounding_sphere_top_tb;
  import mbs_pkg::*;

  localparam int MAX_TRI    = 1024;
  localparam int ITEM_GOAL  = 1700;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 60;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct {
    logic   has_tri;
    logic   last;
    coord_t v[9];
  } tri_item_t;

  typedef struct {
    coord_t            center[3];
    logic [ROOT_W-1:0] radius;
    logic              empty_res;
    logic              overflowed;
  } sphere_t;

  typedef struct {
    logic    has_tri;
    logic    last;
    coord_t  v[9];
    logic    typed;
    sphere_t res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_has_triangle = 1'b0;
  logic in_last = 1'b0;
  coord_t in_v[9] = '{default: '0};
  logic out_valid;
  coord_t out_center_x, out_center_y, out_center_z;
  logic [ROOT_W-1:0] out_radius;
  logic out_empty_res, out_overflowed;

  always #5 clk = ~clk;

  mesh_bounding_sphere_top #(.MAX_TRIANGLES(MAX_TRI)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_has_triangle(in_has_triangle), .in_last(in_last),
    .in_v0_x(in_v[0]), .in_v0_y(in_v[1]), .in_v0_z(in_v[2]),
    .in_v1_x(in_v[3]), .in_v1_y(in_v[4]), .in_v1_z(in_v[5]),
    .in_v2_x(in_v[6]), .in_v2_y(in_v[7]), .in_v2_z(in_v[8]),
    .out_valid(out_valid), .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_center_z(out_center_z), .out_radius(out_radius),
    .out_empty_res(out_empty_res), .out_overflowed(out_overflowed)
  );

  // Mesh state as the block should hold it.
  coord_t  mesh_vtx[$][3];
  coord_t  box_lo[3], box_hi[3];
  logic    mesh_ovf;
  sphere_t spheres_due[$];
  int      errors = 0;
  int      cycles = 0;
  int      item_cnt = 0;
  logic    gaps_on = 1'b1;

  function automatic coord_t box_mid(coord_t a, coord_t b);
    logic signed [COORD_W:0] s;
    s = $signed({a[COORD_W-1], a}) + $signed({b[COORD_W-1], b});
    return coord_t'(s >>> 1);
  endfunction

  function automatic logic [63:0] axis_sq(coord_t p, coord_t c);
    logic signed [COORD_W:0] d;
    logic [63:0] m;
    d = $signed({p[COORD_W-1], p}) - $signed({c[COORD_W-1], c});
    if (d < 0) d = -d;
    m = {32'b0, d[31:0]};
    return m * m;
  endfunction

  function automatic logic [ROOT_W-1:0] floor_root(logic [63:0] n);
    logic [ROOT_W-1:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = {32'b0, r | (32'b1 << b)};
      if (t * t <= n) r = t[31:0];
    end
    return r;
  endfunction

  // Advances the mesh state by one accepted item; returns 1 when a sphere is due.
  function automatic logic mesh_step(tri_item_t it, output sphere_t sp);
    coord_t c[3];
    logic [65:0] sum;
    logic [63:0] best;
    sp = '{center: '{default: '0}, radius: '0, empty_res: 1'b0, overflowed: 1'b0};
    if (it.has_tri) begin
      if (mesh_vtx.size() < 3 * MAX_TRI) begin
        for (int j = 0; j < 3; j++) begin
          coord_t p[3];
          for (int k = 0; k < 3; k++) begin
            p[k] = it.v[3*j+k];
            if (mesh_vtx.size() == 0 || $signed(p[k]) < $signed(box_lo[k])) box_lo[k] = p[k];
            if (mesh_vtx.size() == 0 || $signed(p[k]) > $signed(box_hi[k])) box_hi[k] = p[k];
          end
          mesh_vtx.push_back(p);
        end
      end else begin
        mesh_ovf = 1'b1;
      end
    end
    if (!it.last) return 1'b0;
    if (mesh_vtx.size() == 0) begin
      sp.empty_res = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) c[k] = box_mid(box_lo[k], box_hi[k]);
      best = '0;
      foreach (mesh_vtx[i]) begin
        sum = axis_sq(mesh_vtx[i][0], c[0]) + axis_sq(mesh_vtx[i][1], c[1])
            + axis_sq(mesh_vtx[i][2], c[2]);
        if (sum[65:64] != 0) sum = {2'b0, 64'hFFFF_FFFF_FFFF_FFFF};
        if (sum[63:0] > best) best = sum[63:0];
      end
      sp.center = c;
      sp.radius = floor_root(best);
      sp.overflowed = mesh_ovf;
    end
    mesh_vtx.delete();
    box_lo = '{default: '0};
    box_hi = '{default: '0};
    mesh_ovf = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(tri_item_t it, logic typed = 1'b0, sphere_t typed_res = '{default: '0});
    sphere_t sp;
    start <= 1'b1;
    in_has_triangle <= it.has_tri;
    in_last <= it.last;
    for (int k = 0; k < 9; k++) in_v[k] <= it.v[k];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (mesh_step(it, sp)) spheres_due.push_back(typed ? typed_res : sp);
    if (it.has_tri || it.last) item_cnt++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(15, 80) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord(int style);
    case (style)
      0: return $urandom();
      1: return coord_t'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic tri_item_t rand_tri(int style, logic last);
    tri_item_t it;
    it.has_tri = 1'b1;
    it.last = last;
    for (int k = 0; k < 9; k++) it.v[k] = rand_coord(style);
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    sphere_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (spheres_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual center %h %h %h radius %h",
                 $time, out_center_x, out_center_y, out_center_z, out_radius);
        errors++;
      end else begin
        want = spheres_due.pop_front();
        check_field("center_x", want.center[0], out_center_x);
        check_field("center_y", want.center[1], out_center_y);
        check_field("center_z", want.center[2], out_center_z);
        check_field("radius", want.radius, out_radius);
        check_field("empty_res", 32'(want.empty_res), 32'(out_empty_res));
        check_field("overflowed", 32'(want.overflowed), 32'(out_overflowed));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_CAP) begin
      $display("mesh_bounding_sphere_top verification failed");
      $finish;
    end
  end

  localparam coord_t MX = 32'h7FFF_FFFF;
  localparam coord_t MN = 32'h8000_0000;

  vec_row_t vec_tbl[] = '{
    // Bare end marker straight after reset: an empty mesh.
    '{1'b0, 1'b1, '{default: '0}, 1'b1, '{'{default: '0}, '0, 1'b1, 1'b0}},
    // Neither bit set is ignored.
    '{1'b0, 1'b0, '{default: 32'hFFFF_FFFF}, 1'b0, '{default: '0}},
    '{1'b1, 1'b1, '{default: '0}, 1'b1, '{'{default: '0}, '0, 1'b0, 1'b0}},
    '{1'b1, 1'b1, '{default: MX}, 1'b1, '{'{MX, MX, MX}, '0, 1'b0, 1'b0}},
    '{1'b1, 1'b1, '{default: MN}, 1'b1, '{'{MN, MN, MN}, '0, 1'b0, 1'b0}},
    // Opposite corners: the largest squared distance, which still fits in 64 bits.
    '{1'b1, 1'b1, '{MN, MN, MN, MX, MX, MX, 0, 0, 0}, 1'b0, '{default: '0}},
    '{1'b1, 1'b1, '{MN, 0, 0, MX, 0, 0, 0, 0, 0}, 1'b0, '{default: '0}},
    '{1'b1, 1'b0, '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000},
      1'b0, '{default: '0}},
    '{1'b0, 1'b0, '{default: '0}, 1'b0, '{default: '0}},
    '{1'b1, 1'b0, '{32'hFFFF_0000, 1, 2, 3, 32'hFFFE_0000, 5, 6, 7, 8}, 1'b0, '{default: '0}},
    '{1'b1, 1'b1, '{32'h0003_8000, 32'hFFFF_FFFF, 0, 9, 9, 9, 32'h7000_0000, 1, 1},
      1'b0, '{default: '0}},
    '{1'b1, 1'b0, '{3, 4, 5, 6, 7, 8, 9, 10, 11}, 1'b0, '{default: '0}},
    '{1'b0, 1'b1, '{default: '0}, 1'b0, '{default: '0}},
    '{1'b1, 1'b0, '{MX, MN, 0, MN, MX, 0, 0, 0, MX}, 1'b0, '{default: '0}},
    '{1'b1, 1'b1, '{1, MN, 1, MX, 1, MN, 1, 1, 1}, 1'b0, '{default: '0}},
    '{1'b0, 1'b1, '{default: '0}, 1'b1, '{'{default: '0}, '0, 1'b1, 1'b0}}
  };

  initial begin
    tri_item_t it;
    int n, style;
    logic bare_end;
    box_lo = '{default: '0};
    box_hi = '{default: '0};
    mesh_ovf = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vec_tbl[r]) begin
      it.has_tri = vec_tbl[r].has_tri;
      it.last = vec_tbl[r].last;
      it.v = vec_tbl[r].v;
      send_item(it, vec_tbl[r].typed, vec_tbl[r].res);
    end

    // Hold off until the block has answered everything, then overfill one mesh.
    start <= 1'b0;
    while (spheres_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    gaps_on = 1'b0;
    for (int t = 0; t < MAX_TRI + 3; t++) send_item(rand_tri(t % 3, 1'b0));
    send_item(rand_tri(0, 1'b1));
    gaps_on = 1'b1;

    while (item_cnt < ITEM_GOAL) begin
      n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
      style = $urandom_range(0, 2);
      gaps_on = ($urandom_range(0, 4) != 0);
      bare_end = (n == 0) || ($urandom_range(0, 3) == 0);
      for (int t = 0; t < n; t++) begin
        if ($urandom_range(0, 9) == 0) begin
          it = rand_tri(0, 1'b0);
          it.has_tri = 1'b0;
          send_item(it);
        end
        send_item(rand_tri(style, !bare_end && t == n - 1));
      end
      if (bare_end) begin
        it = rand_tri(0, 1'b1);
        it.has_tri = 1'b0;
        send_item(it);
      end
    end
    start <= 1'b0;
    gaps_on = 1'b1;

    while (spheres_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && spheres_due.size() == 0) begin
      $display("mesh_bounding_sphere_top verification clean");
    end else begin
      $display("mesh_bounding_sphere_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mbs_pkg.sv
rtl/mbs_ram.sv
rtl/mbs_dp.sv
rtl/mbs_ctrl.sv
rtl/mesh_bounding_sphere_top.sv
sim/mesh_bounding_sphere_top_tb.sv
